[rtl/pltc_pkg.sv]
// ----------------------------------------------------------------------------
// pltc_pkg
// Shared types, symbol codes and truth table helpers for the prefix logic
// tautology checker.
// ----------------------------------------------------------------------------
package pltc_pkg;

    localparam int TABLE_W        = 32;
    localparam int SYM_W          = 8;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [SYM_W-1:0] SYM_P = 8'h70;
    localparam logic [SYM_W-1:0] SYM_Q = 8'h71;
    localparam logic [SYM_W-1:0] SYM_R = 8'h72;
    localparam logic [SYM_W-1:0] SYM_S = 8'h73;
    localparam logic [SYM_W-1:0] SYM_T = 8'h74;
    localparam logic [SYM_W-1:0] SYM_K = 8'h4B;
    localparam logic [SYM_W-1:0] SYM_A = 8'h41;
    localparam logic [SYM_W-1:0] SYM_N = 8'h4E;
    localparam logic [SYM_W-1:0] SYM_C = 8'h43;
    localparam logic [SYM_W-1:0] SYM_E = 8'h45;

    localparam logic [TABLE_W-1:0] TBL_P = 32'hAAAA_AAAA;
    localparam logic [TABLE_W-1:0] TBL_Q = 32'hCCCC_CCCC;
    localparam logic [TABLE_W-1:0] TBL_R = 32'hF0F0_F0F0;
    localparam logic [TABLE_W-1:0] TBL_S = 32'hFF00_FF00;
    localparam logic [TABLE_W-1:0] TBL_T = 32'hFFFF_0000;

    typedef enum logic [2:0] {
        OP_AND,
        OP_OR,
        OP_NOT,
        OP_IMP,
        OP_EQV
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               has_first;
        logic [TABLE_W-1:0] first;
    } t_frame;

    typedef struct packed {
        logic  is_op;
        t_op   op;
    } t_decode;

    function automatic t_decode decode_symbol(input logic [SYM_W-1:0] sym);
        t_decode d;
        d.is_op = 1'b1;
        d.op    = OP_AND;
        case (sym)
            SYM_K:   d.op = OP_AND;
            SYM_A:   d.op = OP_OR;
            SYM_N:   d.op = OP_NOT;
            SYM_C:   d.op = OP_IMP;
            SYM_E:   d.op = OP_EQV;
            default: d.is_op = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic [TABLE_W-1:0] leaf_table(input logic [SYM_W-1:0] sym);
        logic [TABLE_W-1:0] t;
        case (sym)
            SYM_P:   t = TBL_P;
            SYM_Q:   t = TBL_Q;
            SYM_R:   t = TBL_R;
            SYM_S:   t = TBL_S;
            SYM_T:   t = TBL_T;
            default: t = '0;
        endcase
        return t;
    endfunction

    // not ignores the first operand
    function automatic logic [TABLE_W-1:0] combine(input t_op op,
                                                   input logic [TABLE_W-1:0] a,
                                                   input logic [TABLE_W-1:0] b);
        logic [TABLE_W-1:0] r;
        case (op)
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_IMP:  r = ~a | b;
            OP_EQV:  r = ~(a ^ b);
            default: r = ~b;
        endcase
        return r;
    endfunction

endpackage

[rtl/pltc_frame_ram.sv]
// ----------------------------------------------------------------------------
// pltc_frame_ram
// Frame stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pltc_frame_ram
    import pltc_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_frame                   i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_frame                   o_rd_data
);

    t_frame r_mem [DEPTH];
    t_frame r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/prefix_logic_tautology_checker.sv]
// ----------------------------------------------------------------------------
// prefix_logic_tautology_checker
// Prefix boolean formula tautology checker over 32-entry truth tables.
// ----------------------------------------------------------------------------
// Symbols arrive one per transaction in prefix order. An operator is pushed
// onto the frame stack. A leaf with no frame open is the whole formula and
// gives the result directly; otherwise it walks the stack, one frame per
// cycle, while it folds finished operators back down; that walk is set by
// the frame memory's single registered read port and one shared combine unit.
// A result (tautology or overflow) is produced when the outermost formula
// closes or when an operator finds STACK_DEPTH frames in use. When idle,
// input is accepted while the result register is empty or being drained.
module prefix_logic_tautology_checker
    import pltc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SYM_W-1:0] i_symbol,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_is_tautology,
    output logic             o_overflow
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_level, n_level;
    logic [TABLE_W-1:0] r_value, n_value;
    logic               r_o_valid, n_o_valid;
    logic               r_taut, n_taut;
    logic               r_ovf, n_ovf;

    logic               accept;
    t_decode            dec;
    t_frame             rd_frame;
    t_frame             wr_frame;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [LW-1:0]      top;
    logic [LW-1:0]      lvl_m1;
    logic [TABLE_W-1:0] comb_out;

    assign o_ready = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign accept  = i_valid && o_ready;
    assign dec     = decode_symbol(i_symbol);
    assign top     = r_level - LW'(1);
    assign comb_out = combine(rd_frame.op, rd_frame.first, r_value);

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_value   = r_value;
        n_o_valid = r_o_valid && !i_ready;
        n_taut    = r_taut;
        n_ovf     = r_ovf;
        wr_en     = 1'b0;
        wr_addr   = r_level[AW-1:0];
        wr_frame  = '{op: dec.op, has_first: 1'b0, first: '0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (dec.is_op) begin
                        if (r_level >= LW'(STACK_DEPTH)) begin
                            n_level   = '0;
                            n_o_valid = 1'b1;
                            n_taut    = 1'b0;
                            n_ovf     = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            n_level = r_level + LW'(1);
                        end
                    end else if (r_level == '0) begin
                        n_o_valid = 1'b1;
                        n_taut    = &leaf_table(i_symbol);
                        n_ovf     = 1'b0;
                    end else begin
                        n_value = leaf_table(i_symbol);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (rd_frame.op != OP_NOT && !rd_frame.has_first) begin
                    wr_en    = 1'b1;
                    wr_addr  = top[AW-1:0];
                    wr_frame = '{op: rd_frame.op, has_first: 1'b1, first: r_value};
                    n_state  = S_IDLE;
                end else begin
                    n_value = comb_out;
                    n_level = top;
                    if (top == '0) begin
                        n_o_valid = 1'b1;
                        n_taut    = &comb_out;
                        n_ovf     = 1'b0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // next read always targets the top frame at the new level
    assign lvl_m1  = n_level - LW'(1);
    assign rd_addr = lvl_m1[AW-1:0];

    pltc_frame_ram #(
        .DEPTH(STACK_DEPTH)
    ) u_frame_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_frame),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_level   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_level   <= n_level;
            r_o_valid <= n_o_valid;
            r_value   <= n_value;
            r_taut    <= n_taut;
            r_ovf     <= n_ovf;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_is_tautology = r_taut;
    assign o_overflow     = r_ovf;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("frame stack level beyond depth");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_level != '0))
        else $error("stack walk with empty stack");

    a_ovf_not_taut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && o_is_tautology))
        else $error("overflow transaction flagged as tautology");

    a_ovf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && dec.is_op && r_level >= LW'(STACK_DEPTH)) |=> (r_level == '0))
        else $error("overflow did not clear the stack");

endmodule
